// ===== design/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg - shared constants for the depth-first topological ordering unit
// Holds the default sizes and the field widths fixed by the interface.
// ----------------------------------------------------------------------------
`default_nettype none
package dfs_pkg;
    localparam int DFS_MAX_NODES = 64;
    localparam int DFS_MAX_EDGES = 256;
    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
endpackage
`default_nettype wire

// ===== design/dfs_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_ram - generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== design/dfs_topological_order_unit.sv =====
// ----------------------------------------------------------------------------
// dfs_topological_order_unit - depth-first topological ordering
// Stores edges, walks the graph depth first, emits reversed finish order.
// ----------------------------------------------------------------------------
// Operation: an edge-only item is stored while loading. A last item starts a walk
// of the stored graph: each edge probe reads edge memory (PROBE), then checks
// the edge (CHECK); each root is picked in ROOT, and each pop adds a POP step
// for the stack-memory read. Results then stream one at a time from the
// finish memory through a one-deep output register; input is held off meanwhile.
// Reset (aresetn, synchronous, active low) clears control state, the fill
// count, the overflow flag and the visited marks; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_topological_order_unit
    import dfs_pkg::*;
#(
    parameter int MAX_NODES = DFS_MAX_NODES,
    parameter int MAX_EDGES = DFS_MAX_EDGES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_has_edge,
    input  wire logic [NODE_W-1:0]  s_edge_source,
    input  wire logic [NODE_W-1:0]  s_edge_dest,
    input  wire logic               s_last_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [NODE_W-1:0]       m_order_node,
    output logic                    m_last_node,
    output logic                    m_edge_overflow
);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EF_W = $clog2(MAX_EDGES + 1);
    localparam int NA_W = $clog2(MAX_NODES);
    localparam int NC_W = $clog2(MAX_NODES + 1);
    localparam int FR_W = NODE_W + EF_W;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_ROOT  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_POP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] node_count_reg;
    logic [EF_W-1:0]    fill_reg, fill_next;
    logic               ovf_reg, ovf_next;
    logic [63:0]        vis_reg, vis_next;
    logic [NC_W-1:0]    root_reg, root_next;
    logic [NC_W-1:0]    sp_reg, sp_next;
    logic [NC_W-1:0]    fin_reg, fin_next;
    logic [NODE_W-1:0]  top_node_reg, top_node_next;
    logic [EF_W-1:0]    pos_reg, pos_next;
    logic [NC_W-1:0]    emit_reg, emit_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               rd_pend_reg, rd_pend_next;

    // effective node count, clamped to 1..MAX_NODES
    logic [NC_W-1:0] cnt;
    always_comb begin
        if (node_count_reg == '0) begin
            cnt = NC_W'(1);
        end else if (32'(node_count_reg) > MAX_NODES) begin
            cnt = NC_W'(MAX_NODES);
        end else begin
            cnt = NC_W'(node_count_reg);
        end
    end

    // edge memory
    logic                    e_we;
    logic [EA_W-1:0]         e_waddr, e_raddr;
    logic [2*NODE_W-1:0]     e_rdata;
    // stack memory: node, next edge position
    logic                    k_we;
    logic [NA_W-1:0]         k_waddr, k_raddr;
    logic [FR_W-1:0]         k_wdata, k_rdata;
    // finish memory
    logic                    f_we;
    logic [NA_W-1:0]         f_waddr, f_raddr;
    logic [NODE_W-1:0]       f_rdata;

    dfs_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .wr_en(e_we), .wr_addr(e_waddr),
        .wr_data({s_edge_source, s_edge_dest}), .rd_addr(e_raddr), .rd_data(e_rdata)
    );
    dfs_ram #(.WIDTH(FR_W), .DEPTH(MAX_NODES)) u_stack_ram (
        .aclk(aclk), .wr_en(k_we), .wr_addr(k_waddr),
        .wr_data(k_wdata), .rd_addr(k_raddr), .rd_data(k_rdata)
    );
    dfs_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish_ram (
        .aclk(aclk), .wr_en(f_we), .wr_addr(f_waddr),
        .wr_data(top_node_reg), .rd_addr(f_raddr), .rd_data(f_rdata)
    );

    logic s_xfer, m_xfer;
    assign s_ready = (state_reg == ST_LOAD);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;

    logic [NODE_W-1:0] e_src, e_dst;
    assign e_src = e_rdata[2*NODE_W-1:NODE_W];
    assign e_dst = e_rdata[NODE_W-1:0];

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        vis_next       = vis_reg;
        root_next      = root_reg;
        sp_next        = sp_reg;
        fin_next       = fin_reg;
        top_node_next  = top_node_reg;
        pos_next       = pos_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        rd_pend_next   = 1'b0;
        e_we    = 1'b0;
        e_waddr = fill_reg[EA_W-1:0];
        e_raddr = pos_reg[EA_W-1:0];
        k_we    = 1'b0;
        k_waddr = sp_reg[NA_W-1:0];
        k_wdata = {top_node_reg, pos_reg};
        k_raddr = NA_W'(sp_reg - NC_W'(1));
        f_we    = 1'b0;
        f_waddr = fin_reg[NA_W-1:0];
        f_raddr = NA_W'(fin_reg - NC_W'(1) - emit_reg);
        case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    if (s_has_edge) begin
                        if (32'(fill_reg) < MAX_EDGES) begin
                            e_we      = 1'b1;
                            fill_next = fill_reg + EF_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_last_item) begin
                        vis_next   = '0;
                        root_next  = '0;
                        fin_next   = '0;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                // pick the next unvisited root, or finish the walk
                if (root_reg >= cnt) begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    root_next = root_reg + NC_W'(1);
                    if (!vis_reg[root_reg[NA_W-1:0]]) begin
                        vis_next[root_reg[NA_W-1:0]] = 1'b1;
                        top_node_next = NODE_W'(root_reg);
                        pos_next      = '0;
                        sp_next       = NC_W'(1);
                        state_next    = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                // issue a read of the edge at pos, or finish this node
                if (pos_reg >= fill_reg) begin
                    f_we     = 1'b1;
                    fin_next = fin_reg + NC_W'(1);
                    sp_next  = sp_reg - NC_W'(1);
                    if (sp_reg == NC_W'(1)) begin
                        state_next = ST_ROOT;
                    end else begin
                        k_raddr    = NA_W'(sp_reg - NC_W'(2));
                        state_next = ST_POP;
                    end
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (e_src == top_node_reg && 32'(e_dst) < 32'(cnt) && !vis_reg[e_dst]
                    && 32'(sp_reg) < MAX_NODES) begin
                    // push: save parent frame with resume point, descend
                    k_we    = 1'b1;
                    k_waddr = NA_W'(sp_reg - NC_W'(1));
                    k_wdata = {top_node_reg, pos_reg + EF_W'(1)};
                    vis_next[e_dst] = 1'b1;
                    top_node_next = e_dst;
                    pos_next      = '0;
                    sp_next       = sp_reg + NC_W'(1);
                end else begin
                    pos_next = pos_reg + EF_W'(1);
                end
                state_next = ST_PROBE;
            end
            ST_POP: begin
                // stack read data for the new top is ready
                top_node_next = k_rdata[FR_W-1:EF_W];
                pos_next      = k_rdata[EF_W-1:0];
                state_next    = ST_PROBE;
            end
            ST_EMIT: begin
                // stream finish list in reverse through a one-deep output register
                if (m_xfer) begin
                    out_valid_next = 1'b0;
                end
                if (rd_pend_reg) begin
                    out_valid_next = 1'b1;
                    out_last_next  = (emit_reg == fin_reg);
                    out_ovf_next   = ovf_reg;
                end else if ((!out_valid_reg || m_xfer) && emit_reg < fin_reg) begin
                    rd_pend_next = 1'b1;
                    emit_next    = emit_reg + NC_W'(1);
                end else if ((!out_valid_reg || m_xfer) && emit_reg == fin_reg) begin
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            node_count_reg <= COUNT_W'(1);
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            vis_reg        <= '0;
            root_reg       <= '0;
            sp_reg         <= '0;
            fin_reg        <= '0;
            emit_reg       <= '0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            vis_reg       <= vis_next;
            root_reg      <= root_next;
            sp_reg        <= sp_next;
            fin_reg       <= fin_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
        top_node_reg <= top_node_next;
        pos_reg      <= pos_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // hold the emitted node alongside its flags
    logic [NODE_W-1:0] out_node_reg;
    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            out_node_reg <= f_rdata;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_order_node    = out_node_reg;
    assign m_last_node     = out_last_reg;
    assign m_edge_overflow = out_ovf_reg;

    // results only appear while emitting
    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_EMIT)
        else $error("result valid outside emit phase");
    // no input transfer while a walk runs
    a_no_load_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |-> !s_ready)
        else $error("ready during walk");
    // stack depth never exceeds the node limit
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= MAX_NODES)
        else $error("stack overflow");
endmodule
`default_nettype wire

// ===== bench/dfs_topological_order_unit_tb.sv =====
// ----------------------------------------------------------------------------
// dfs_topological_order_unit_tb - self-checking bench for the ordering unit
// Loads edge lists over the input channel, triggers ordering runs, and checks
// every emitted node against a behavioral depth-first predictor. A short
// table of directed cases comes first, then random loads across node counts.
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_topological_order_unit_tb;
    import dfs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              ovf;
    } order_t;

    // One row of the directed table. A row with cfg_en writes node_count
    // first (once idle); a row with typed set carries the one result it
    // should produce instead of the predicted one.
    typedef struct {
        bit                 cfg_en;
        logic [COUNT_W-1:0] cfg_val;
        bit                 has;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  dst;
        bit                 last;
        bit                 typed;
        logic [NODE_W-1:0]  tnode;
    } row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_has_edge;
    logic [NODE_W-1:0]  s_edge_source;
    logic [NODE_W-1:0]  s_edge_dest;
    logic               s_last_item;
    logic               m_valid;
    logic               m_ready;
    logic [NODE_W-1:0]  m_order_node;
    logic               m_last_node;
    logic               m_edge_overflow;

    // Predictor state: loaded edges, overflow flag and node count.
    logic [NODE_W-1:0]  pend_src[$];
    logic [NODE_W-1:0]  pend_dst[$];
    bit                 pend_ovf;
    logic [COUNT_W-1:0] node_count_reg;
    order_t             order_q[$];

    int errors;
    int cycles;
    int items_sent;
    int runs_done;
    int nodes_seen;
    int burst_left;
    int gap_max;
    int ready_mode;
    int mode_left;

    dfs_topological_order_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_has_edge      (s_has_edge),
        .s_edge_source   (s_edge_source),
        .s_edge_dest     (s_edge_dest),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_order_node    (m_order_node),
        .m_last_node     (m_last_node),
        .m_edge_overflow (m_edge_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Store an edge and, on a last item, walk the graph depth first and
    // queue the reversed finishing order.
    function automatic void predict_topo_order(bit has, logic [NODE_W-1:0] src,
                                               logic [NODE_W-1:0] dst, bit last);
        int                cnt;
        int                sp;
        int                p;
        int                fin;
        int                root;
        bit                found;
        logic [NODE_W-1:0] child;
        logic [63:0]       seen;
        logic [NODE_W-1:0] stk_node[64];
        int                stk_pos[64];
        logic [NODE_W-1:0] fin_list[64];
        order_t            r;
        if (has) begin
            if (pend_src.size() < DFS_MAX_EDGES) begin
                pend_src.insert(pend_src.size(), src);
                pend_dst.insert(pend_dst.size(), dst);
            end else begin
                pend_ovf = 1'b1;
            end
        end
        if (!last) return;
        cnt = node_count_reg;
        if (cnt < 1) cnt = 1;
        if (cnt > DFS_MAX_NODES) cnt = DFS_MAX_NODES;
        seen = '0;
        fin  = 0;
        for (root = 0; root < cnt; root++) begin
            if (seen[root]) continue;
            seen[root]  = 1'b1;
            stk_node[0] = NODE_W'(root);
            stk_pos[0]  = 0;
            sp = 1;
            while (sp > 0) begin
                p     = stk_pos[sp-1];
                found = 1'b0;
                child = '0;
                while (p < pend_src.size()) begin
                    if (pend_src[p] == stk_node[sp-1] && pend_dst[p] < cnt
                            && !seen[pend_dst[p]]) begin
                        found = 1'b1;
                        child = pend_dst[p];
                        break;
                    end
                    p++;
                end
                if (found && sp < DFS_MAX_NODES) begin
                    // descend: resume the parent after this edge later
                    stk_pos[sp-1] = p + 1;
                    seen[child]   = 1'b1;
                    stk_node[sp]  = child;
                    stk_pos[sp]   = 0;
                    sp++;
                end else begin
                    if (fin < DFS_MAX_NODES) fin_list[fin++] = stk_node[sp-1];
                    sp--;
                end
            end
        end
        for (int k = 0; k < fin; k++) begin
            r.node = fin_list[fin-1-k];
            r.last = (k == fin - 1);
            r.ovf  = pend_ovf;
            order_q.insert(order_q.size(), r);
        end
        pend_src.delete();
        pend_dst.delete();
        pend_ovf = 1'b0;
    endfunction

    // Present one item; hold it until the transfer, then predict.
    task automatic send_item(bit has, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                             bit last);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_has_edge    <= has;
        s_edge_source <= src;
        s_edge_dest   <= dst;
        s_last_item   <= last;
        do @(posedge aclk); while (!s_ready);
        predict_topo_order(has, src, dst, last);
        items_sent++;
        if (last) runs_done++;
    endtask

    // Burst pacing: drop valid for a random gap once a burst runs out.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left > 0 || gap_max == 0) return;
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(1, gap_max);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge aclk);
    endtask

    // Drain all results, let the block settle, then write node_count.
    task automatic write_node_count(logic [COUNT_W-1:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (order_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        node_count_reg = val;
    endtask

    // Receiver: switch between no stall, light and heavy stall patterns.
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                m_ready <= ($urandom_range(0, 9) < 2);
            end
        endcase
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        order_t e;
        if (aresetn && m_valid && m_ready) begin
            nodes_seen++;
            if (order_q.size() == 0) begin
                $error("unexpected result: order_node=%0d", m_order_node);
                errors++;
            end else begin
                e = order_q.pop_front();
                if (m_order_node !== e.node) begin
                    $error("order_node: expected %0d, got %0d", e.node, m_order_node);
                    errors++;
                end
                if (m_last_node !== e.last) begin
                    $error("last_node: expected %0d, got %0d", e.last, m_last_node);
                    errors++;
                end
                if (m_edge_overflow !== e.ovf) begin
                    $error("edge_overflow: expected %0d, got %0d", e.ovf, m_edge_overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dfs_topological_order_unit: mismatch");
            $finish;
        end
    end

    initial begin
        row_t              tbl[$];
        row_t              rw;
        int                qsz;
        int                n_edges;
        int                cnt;
        int                n_loads;
        int                phase;
        bit                big_done;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [COUNT_W-1:0] cval;
        order_t            t;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_has_edge     = 1'b0;
        s_edge_source  = '0;
        s_edge_dest    = '0;
        s_last_item    = 1'b0;
        m_ready        = 1'b0;
        ready_mode     = 0;
        mode_left      = 0;
        errors         = 0;
        cycles         = 0;
        items_sent     = 0;
        runs_done      = 0;
        nodes_seen     = 0;
        pend_ovf       = 1'b0;
        node_count_reg = 1;
        burst_left     = 1;
        gap_max        = 4;
        big_done       = 1'b0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // cfg_en cfg_val has src dst last typed tnode
        tbl = '{
            // reset count of one, empty load
            '{0, 7'd0,   0, 6'd0,  6'd0,  1, 1, 6'd0},
            // out-of-range edge and self loop, single node
            '{0, 7'd0,   1, 6'd63, 6'd63, 0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd0,  6'd0,  1, 1, 6'd0},
            // chain of three
            '{1, 7'd3,   1, 6'd0,  6'd1,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd1,  6'd2,  0, 0, 6'd0},
            '{0, 7'd0,   0, 6'd0,  6'd0,  1, 0, 6'd0},
            // cycle plus duplicates, edge on the last item
            '{0, 7'd0,   1, 6'd2,  6'd0,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd0,  6'd1,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd0,  6'd1,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd1,  6'd2,  1, 0, 6'd0},
            // count zero is taken as one
            '{1, 7'd0,   1, 6'd0,  6'd5,  1, 1, 6'd0},
            // full graph, extreme ids
            '{1, 7'd64,  1, 6'd63, 6'd0,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd0,  6'd63, 0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd42, 6'd21, 1, 0, 6'd0},
            // count above the maximum clamps to 64
            '{1, 7'd127, 1, 6'd5,  6'd4,  0, 0, 6'd0},
            '{0, 7'd0,   1, 6'd4,  6'd63, 0, 0, 6'd0},
            '{0, 7'd0,   0, 6'd0,  6'd0,  1, 0, 6'd0}
        };
        foreach (tbl[i]) begin
            rw = tbl[i];
            if (rw.cfg_en) write_node_count(rw.cfg_val);
            qsz = order_q.size();
            send_item(rw.has, rw.src, rw.dst, rw.last);
            if (rw.typed) begin
                while (order_q.size() > qsz) void'(order_q.pop_back());
                t.node = rw.tnode;
                t.last = 1'b1;
                t.ovf  = 1'b0;
                order_q.insert(order_q.size(), t);
            end
            pace_sender();
        end

        // Random phases: each picks a node count, then loads a few graphs.
        phase = 0;
        while (items_sent < 420) begin
            case (phase)
                0: cval = 7'd64;
                1: cval = 7'd1;
                2: cval = 7'd127;
                3: cval = 7'd0;
                4: cval = 7'd2;
                default: cval = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                            : 7'($urandom_range(1, 24));
            endcase
            write_node_count(cval);
            cnt = (cval == 0) ? 1 : (cval > 64) ? 64 : cval;
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            n_loads = $urandom_range(1, 5);
            repeat (n_loads) begin
                n_edges = $urandom_range(0, 15);
                // one load overflows the edge store
                if (!big_done && cnt == 64 && phase > 0) begin
                    n_edges = DFS_MAX_EDGES + 3;
                    big_done = 1'b1;
                end
                repeat (n_edges) begin
                    if ($urandom_range(0, 6) != 0) begin
                        a = NODE_W'($urandom_range(0, cnt - 1));
                        b = NODE_W'($urandom_range(0, cnt - 1));
                    end else begin
                        a = NODE_W'($urandom_range(0, 63));
                        b = NODE_W'($urandom_range(0, 63));
                    end
                    send_item(1'b1, a, b, 1'b0);
                    pace_sender();
                end
                send_item(1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, cnt - 1)),
                          NODE_W'($urandom_range(0, cnt - 1)), 1'b1);
                pace_sender();
            end
            phase++;
        end

        // Drain and settle.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (order_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("ran %0d items in %0d ordering runs over %0d phases;", items_sent,
                 runs_done, phase);
        $display("checked %0d emitted nodes, overflow load exercised: %0d", nodes_seen,
                 big_done);
        if (errors == 0) begin
            $display("dfs_topological_order_unit: match");
        end else begin
            $display("dfs_topological_order_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/dfs_pkg.sv
design/dfs_ram.sv
design/dfs_topological_order_unit.sv
bench/dfs_topological_order_unit_tb.sv
